// ===== hw/rtl/alst_pkg.sv =====
// ----------------------------------------------------------------------------
// alst_pkg
// Shared widths, request codes and the per-cell command type of the
// array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package alst_pkg;

   localparam int MODE_W = 3;
   localparam int POS_W  = 6;
   localparam int VAL_W  = 16;
   localparam int LEN_W  = 7;

   localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRITE  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

   typedef struct packed {
      logic append;
      logic insert;
      logic remove;
      logic write;
      logic read;
   } alst_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/array_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_list_engine_top
// Ordered list of up to DEPTH elements held in a row of shifting cells.
//
// Usage:
//   A request transfers at a rising edge where start is high and busy is
//   low; req_mode selects append, insert, delete, write or read, with
//   req_position and req_element_value as operands.
//   Every request gives one response, shown on the rsp_ ports for exactly
//   one cycle with rsp_strobe high, in the cycle right after the request
//   transfer. The receiver cannot stall; responses are never held back.
//   A new request may transfer every cycle:
//   all cells shift together, so an insert or delete over the whole list
//   finishes in the same cycle as a write. The response path is one
//   compare per cell and an OR over the cells for reads.
//   Reset clears the length to zero; busy is high during reset and clears
//   once reset is low. Element contents are not cleared and only slots below
//   the length are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine_top
   import alst_pkg::*;
#(
   parameter int DEPTH      = 64,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [MODE_W-1:0] req_mode,
   input  wire logic [POS_W-1:0]  req_position,
   input  wire logic [VAL_W-1:0]  req_element_value,
   output logic                   rsp_strobe,
   output logic                   rsp_ok,
   output logic      [VAL_W-1:0]  rsp_read_value,
   output logic      [LEN_W-1:0]  rsp_length,
   output logic                   rsp_is_empty,
   output logic                   rsp_is_full
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic                  busy_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  strobe_ff;
   logic                  ok_ff;
   logic                  ok_in;
   logic [VAL_W-1:0]      read_ff;
   logic [VAL_W-1:0]      read_in;

   logic                  accept;
   logic [CMP_W-1:0]      pos_cmp;
   logic [CMP_W-1:0]      cnt_cmp;
   logic                  full;
   logic                  in_range;
   alst_cmd_type          decoded;
   alst_cmd_type          cmd;
   logic [ELEM_WIDTH+VAL_W-1:0] value_ext;
   logic [ELEM_WIDTH-1:0] new_value;
   logic [ELEM_WIDTH-1:0] read_sel;
   logic [ELEM_WIDTH+VAL_W-1:0] read_ext;

   logic [ELEM_WIDTH-1:0] cell_value [DEPTH];
   logic [ELEM_WIDTH-1:0] cell_read  [DEPTH];

   assign accept    = start && !busy_ff;
   assign pos_cmp   = CMP_W'(req_position);
   assign cnt_cmp   = CMP_W'(count_ff);
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign in_range  = (pos_cmp < cnt_cmp);
   assign value_ext = {{ELEM_WIDTH{1'b0}}, req_element_value};
   assign new_value = value_ext[ELEM_WIDTH-1:0];

   always_comb begin
      decoded = '0;
      ok_in   = 1'b0;
      unique case (req_mode)
         MODE_APPEND: begin
            decoded.append = 1'b1;
            ok_in          = !full;
         end
         MODE_INSERT: begin
            decoded.insert = 1'b1;
            ok_in          = !full && (pos_cmp <= cnt_cmp);
         end
         MODE_REMOVE: begin
            decoded.remove = 1'b1;
            ok_in          = in_range;
         end
         MODE_WRITE: begin
            decoded.write = 1'b1;
            ok_in         = in_range;
         end
         MODE_READ: begin
            decoded.read = 1'b1;
            ok_in        = in_range;
         end
         default: begin
            decoded = '0;
            ok_in   = 1'b0;
         end
      endcase
   end

   assign cmd = (accept && ok_in) ? decoded : '0;

   always_comb begin
      count_in = count_ff;
      if (cmd.append || cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ELEM_WIDTH-1:0] left_value;
      logic [ELEM_WIDTH-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_right
         assign right_value = cell_value[i+1];
      end

      alst_cell #(
         .INDEX      (i),
         .CMP_W      (CMP_W),
         .ELEM_WIDTH (ELEM_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .pos_cmp     (pos_cmp),
         .cnt_cmp     (cnt_cmp),
         .new_value   (new_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_value[i]),
         .read_value  (cell_read[i])
      );
   end

   // at most one cell drives a nonzero read value
   always_comb begin
      read_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_sel = read_sel | cell_read[i];
      end
   end

   assign read_ext = {{VAL_W{1'b0}}, read_sel};
   assign read_in  = read_ext[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         busy_ff   <= 1'b0;
         count_ff  <= count_in;
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      ok_ff   <= ok_in;
      read_ff <= read_in;
   end

   assign busy           = busy_ff;
   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = ok_ff;
   assign rsp_read_value = read_ff;
   assign rsp_length     = LEN_W'(count_ff);
   assign rsp_is_empty   = (count_ff == '0);
   assign rsp_is_full    = full;

   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request transfer without response");

   a_no_extra_resp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without request transfer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("length beyond capacity");

   a_fail_holds_count: assert property (@(posedge clock) disable iff (reset)
      (accept && !ok_in) |=> $stable(count_ff))
      else $error("failed request changed the length");

   a_fail_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_read_value == '0))
      else $error("failed request returned read data");

endmodule

`default_nettype wire

// ===== hw/rtl/alst_cell.sv =====
// ----------------------------------------------------------------------------
// alst_cell
// One slot of the list: holds a single element and takes a new value from
// the request, from its lower neighbor or from its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module alst_cell
   import alst_pkg::*;
#(
   parameter int INDEX      = 0,
   parameter int CMP_W      = 7,
   parameter int ELEM_WIDTH = 16
) (
   input  wire logic                  clock,
   input  wire alst_cmd_type          cmd,
   input  wire logic [CMP_W-1:0]      pos_cmp,
   input  wire logic [CMP_W-1:0]      cnt_cmp,
   input  wire logic [ELEM_WIDTH-1:0] new_value,
   input  wire logic [ELEM_WIDTH-1:0] left_value,
   input  wire logic [ELEM_WIDTH-1:0] right_value,
   output logic      [ELEM_WIDTH-1:0] value,
   output logic      [ELEM_WIDTH-1:0] read_value
);

   localparam logic [CMP_W-1:0] IDX = CMP_W'(INDEX);

   logic [ELEM_WIDTH-1:0] elem_ff;
   logic [ELEM_WIDTH-1:0] elem_in;
   logic                  at_pos;
   logic                  above_pos;

   assign at_pos    = (IDX == pos_cmp);
   assign above_pos = (IDX > pos_cmp);

   always_comb begin
      elem_in = elem_ff;
      if (cmd.append && (IDX == cnt_cmp)) begin
         elem_in = new_value;
      end else if (cmd.insert && at_pos) begin
         elem_in = new_value;
      end else if (cmd.insert && above_pos) begin
         elem_in = left_value;
      end else if (cmd.remove && (at_pos || above_pos)) begin
         elem_in = right_value;
      end else if (cmd.write && at_pos) begin
         elem_in = new_value;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign value      = elem_ff;
   assign read_value = (cmd.read && at_pos) ? elem_ff : '0;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for array_list_engine_top. A short table of directed
// requests covers the empty and out-of-range cases and the unused modes.
// Random traffic follows, biased to grow and shrink the list so that it
// reaches both empty and full. A behavioral list predicts every response
// that the table does not give, and each is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import alst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_DEPTH  = 64;
   localparam int PHASE_ITEMS = 620;
   localparam int STALL_LIMIT = 2000;

   localparam logic [MODE_W-1:0] MODE_SPARE5 = 3'd5;
   localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;

   typedef struct packed {
      logic              ok;
      logic [VAL_W-1:0]  read_value;
      logic [LEN_W-1:0]  length;
      logic              is_empty;
      logic              is_full;
   } list_result_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  val;
      logic              typed;
      list_result_type   want;
   } list_step_type;

   localparam list_result_type EMPTY_FAIL = '{1'b0, 16'h0000, 7'd0, 1'b1, 1'b0};
   localparam list_result_type UNTYPED    = '{1'b0, 16'h0000, 7'd0, 1'b0, 1'b0};
   localparam int NUM_DIRECTED = 22;

   list_step_type directed_steps [0:NUM_DIRECTED-1] = '{
      '{MODE_READ,   6'd0,  16'h0000, 1'b1, EMPTY_FAIL},
      '{MODE_REMOVE, 6'd0,  16'h0000, 1'b1, EMPTY_FAIL},
      '{MODE_WRITE,  6'd63, 16'hffff, 1'b1, EMPTY_FAIL},
      '{MODE_SPARE5, 6'd0,  16'h0000, 1'b1, EMPTY_FAIL},
      '{MODE_SPARE7, 6'd63, 16'hffff, 1'b1, EMPTY_FAIL},
      '{MODE_INSERT, 6'd1,  16'hffff, 1'b1, EMPTY_FAIL},
      '{MODE_INSERT, 6'd0,  16'h0000, 1'b1, '{1'b1, 16'h0000, 7'd1, 1'b0, 1'b0}},
      '{MODE_APPEND, 6'd63, 16'hffff, 1'b1, '{1'b1, 16'h0000, 7'd2, 1'b0, 1'b0}},
      '{MODE_READ,   6'd1,  16'h0000, 1'b1, '{1'b1, 16'hffff, 7'd2, 1'b0, 1'b0}},
      '{MODE_READ,   6'd2,  16'h0000, 1'b1, '{1'b0, 16'h0000, 7'd2, 1'b0, 1'b0}},
      '{MODE_INSERT, 6'd2,  16'h8001, 1'b0, UNTYPED},
      '{MODE_INSERT, 6'd0,  16'h1234, 1'b0, UNTYPED},
      '{MODE_WRITE,  6'd3,  16'ha5a5, 1'b0, UNTYPED},
      '{MODE_READ,   6'd3,  16'h0000, 1'b0, UNTYPED},
      '{MODE_READ,   6'd0,  16'h0000, 1'b0, UNTYPED},
      '{MODE_SPARE6, 6'd2,  16'h5a5a, 1'b0, UNTYPED},
      '{MODE_REMOVE, 6'd3,  16'h0000, 1'b0, UNTYPED},
      '{MODE_REMOVE, 6'd0,  16'h0000, 1'b0, UNTYPED},
      '{MODE_WRITE,  6'd5,  16'hbeef, 1'b0, UNTYPED},
      '{MODE_REMOVE, 6'd63, 16'h0000, 1'b0, UNTYPED},
      '{MODE_READ,   6'd1,  16'h0000, 1'b0, UNTYPED},
      '{MODE_APPEND, 6'd0,  16'h7fff, 1'b0, UNTYPED}
   };

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [MODE_W-1:0] req_mode = '0;
   logic [POS_W-1:0]  req_position = '0;
   logic [VAL_W-1:0]  req_element_value = '0;
   logic              busy;
   logic              rsp_strobe;
   logic              rsp_ok;
   logic [VAL_W-1:0]  rsp_read_value;
   logic [LEN_W-1:0]  rsp_length;
   logic              rsp_is_empty;
   logic              rsp_is_full;

   logic [VAL_W-1:0]  list_mem [LIST_DEPTH];
   int                list_len = 0;
   list_result_type   pending_results [$];
   int                fail_count = 0;
   int                quiet_cycles = 0;

   array_list_engine_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_ok            (rsp_ok),
      .rsp_read_value    (rsp_read_value),
      .rsp_length        (rsp_length),
      .rsp_is_empty      (rsp_is_empty),
      .rsp_is_full       (rsp_is_full)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic list_result_type apply_list_op(input logic [MODE_W-1:0] mode,
                                                     input logic [POS_W-1:0]  pos,
                                                     input logic [VAL_W-1:0]  val);
      list_result_type res;
      int              p;
      int              i;
      res = '0;
      p = int'(pos);
      case (mode)
         MODE_APPEND: begin
            if (list_len < LIST_DEPTH) begin
               list_mem[list_len] = val;
               list_len++;
               res.ok = 1'b1;
            end
         end
         MODE_INSERT: begin
            if (list_len < LIST_DEPTH && p <= list_len) begin
               for (i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
               list_mem[p] = val;
               list_len++;
               res.ok = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (p < list_len) begin
               for (i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
               list_len--;
               res.ok = 1'b1;
            end
         end
         MODE_WRITE: begin
            if (p < list_len) begin
               list_mem[p] = val;
               res.ok = 1'b1;
            end
         end
         MODE_READ: begin
            if (p < list_len) begin
               res.read_value = list_mem[p];
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      res.length   = LEN_W'(list_len);
      res.is_empty = (list_len == 0);
      res.is_full  = (list_len == LIST_DEPTH);
      return res;
   endfunction

   function automatic void pick_list_op(input int grow_pct,
                                        output logic [MODE_W-1:0] mode,
                                        output logic [POS_W-1:0]  pos,
                                        output logic [VAL_W-1:0]  val);
      int kind;
      kind = $urandom_range(99);
      if (kind < 5) begin
         mode = MODE_W'($urandom);
      end else if (kind < 40) begin
         mode = ($urandom_range(1) == 0) ? MODE_WRITE : MODE_READ;
      end else if ($urandom_range(99) < grow_pct) begin
         mode = ($urandom_range(1) == 0) ? MODE_APPEND : MODE_INSERT;
      end else begin
         mode = MODE_REMOVE;
      end
      if ($urandom_range(9) == 0) begin
         pos = POS_W'($urandom);
      end else if (mode == MODE_INSERT) begin
         pos = POS_W'($urandom_range(list_len >= LIST_DEPTH ? LIST_DEPTH - 1 : list_len));
      end else begin
         pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1)) : '0;
      end
      case ($urandom_range(9))
         0:       val = '0;
         1:       val = '1;
         default: val = VAL_W'($urandom);
      endcase
   endfunction

   // hold the request until it transfers
   task automatic issue_request(input logic [MODE_W-1:0] mode,
                                input logic [POS_W-1:0]  pos,
                                input logic [VAL_W-1:0]  val);
      start             <= 1'b1;
      req_mode          <= mode;
      req_position      <= pos;
      req_element_value <= val;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
   endtask

   task automatic idle_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start             <= 1'b0;
         req_mode          <= MODE_W'($urandom);
         req_position      <= POS_W'($urandom);
         req_element_value <= VAL_W'($urandom);
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      list_result_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("response with no request outstanding");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
               fail_count++;
            end
            if (rsp_read_value !== want.read_value) begin
               $error("read_value: expected %h, got %h", want.read_value, rsp_read_value);
               fail_count++;
            end
            if (rsp_length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_length);
               fail_count++;
            end
            if (rsp_is_empty !== want.is_empty) begin
               $error("is_empty: expected %0d, got %0d", want.is_empty, rsp_is_empty);
               fail_count++;
            end
            if (rsp_is_full !== want.is_full) begin
               $error("is_full: expected %0d, got %0d", want.is_full, rsp_is_full);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      int                idle_pcts [3];
      int                item_idx;
      int                grow_pct;
      list_result_type   res;
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  pos;
      logic [VAL_W-1:0]  val;
      idle_pcts = '{27, 63, 0};
      item_idx = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[k]) begin
         issue_request(directed_steps[k].mode, directed_steps[k].pos, directed_steps[k].val);
         res = apply_list_op(directed_steps[k].mode, directed_steps[k].pos,
                             directed_steps[k].val);
         pending_results.push_back(directed_steps[k].typed ? directed_steps[k].want : res);
         idle_gap(idle_pcts[0]);
      end

      foreach (idle_pcts[ph]) begin
         repeat (PHASE_ITEMS) begin
            // alternate between filling and draining the list
            grow_pct = ((item_idx / 200) % 2 == 0) ? 85 : 15;
            pick_list_op(grow_pct, mode, pos, val);
            issue_request(mode, pos, val);
            pending_results.push_back(apply_list_op(mode, pos, val));
            item_idx++;
            idle_gap(idle_pcts[ph]);
         end
      end

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
hw/rtl/alst_pkg.sv
hw/rtl/alst_cell.sv
hw/rtl/array_list_engine_top.sv
test/tb.sv
